FILE: rtl/tsgf_pkg.sv
// ----------------------------------------------------------------------------
// tsgf_pkg: shared types and constants of the time series gap filler
// field widths, register indexes, controller states, command and status groups
// ----------------------------------------------------------------------------
package tsgf_pkg;

	localparam int TIME_W         = 48;
	localparam int VAL_W          = 32;
	localparam int NUM_VALUES     = 4;
	localparam int DATA_W         = TIME_W + NUM_VALUES * VAL_W;
	localparam int OUT_USER_W     = 2;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 48;
	localparam int DEF_COMPONENTS = 4;
	localparam int DEF_MAX_FILLS  = 63;

	// remainder divider: one quotient bit a cycle
	localparam int DIV_STEPS = TIME_W;
	localparam int CNT_W     = $clog2(DIV_STEPS + 1);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RESOLUTION  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FILL_VALUE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_BOUND   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_ENABLE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_BOUND   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ENABLE  = 3'd5;

	// output tuser bit positions
	localparam int USER_IS_FILL = 0;
	localparam int USER_DROPPED = 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_PRE,
		ST_SAMP,
		ST_POST
	} state_t;

	typedef struct packed {
		logic capture;
		logic div_step;
		logic lead_start;
		logic pre_step;
		logic pre_end;
		logic samp_step;
		logic post_step;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic go_gap;
		logic go_lead;
		logic div_done;
		logic pre_fill;
		logic trail_go;
		logic post_last;
	} sts_t;

endpackage

FILE: rtl/tsgf_ctrl.sv
// ----------------------------------------------------------------------------
// tsgf_ctrl: sequencing controller of the gap filler
// walks each request through remainder division, leading or gap fills, the
// sample itself and trailing fills
// ----------------------------------------------------------------------------
module tsgf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_valid,
	output logic          s_ready,
	output tsgf_pkg::cmd_t cmd,
	input  tsgf_pkg::sts_t sts
);
	import tsgf_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_valid) begin
					if (sts.go_gap) begin
						state_d = ST_PRE;
					end else if (sts.go_lead) begin
						state_d = ST_DIV;
					end else begin
						state_d = ST_SAMP;
					end
				end
			end
			ST_DIV: begin
				if (sts.div_done) begin
					state_d = ST_PRE;
				end
			end
			ST_PRE: begin
				if (sts.out_free && !sts.pre_fill) begin
					state_d = ST_SAMP;
				end
			end
			ST_SAMP: begin
				if (sts.out_free) begin
					state_d = sts.trail_go ? ST_POST : ST_IDLE;
				end
			end
			ST_POST: begin
				if (sts.out_free && sts.post_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd     = '0;
		s_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_ready     = 1'b1;
				cmd.capture = s_valid;
			end
			ST_DIV: begin
				cmd.div_step   = !sts.div_done;
				cmd.lead_start = sts.div_done;
			end
			ST_PRE: begin
				cmd.pre_step = sts.out_free && sts.pre_fill;
				cmd.pre_end  = sts.out_free && !sts.pre_fill;
			end
			ST_SAMP: begin
				cmd.samp_step = sts.out_free;
			end
			ST_POST: begin
				cmd.post_step = sts.out_free;
			end
			default: begin
				cmd     = '0;
				s_ready = 1'b0;
			end
		endcase
	end

endmodule

FILE: rtl/tsgf_dp.sv
// ----------------------------------------------------------------------------
// tsgf_dp: datapath of the gap filler
// configuration registers, series state, fill time stepper, bit-serial
// remainder unit and the output register
// ----------------------------------------------------------------------------
module tsgf_dp #(
	parameter int COMPONENTS = tsgf_pkg::DEF_COMPONENTS,
	parameter int MAX_FILLS  = tsgf_pkg::DEF_MAX_FILLS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tsgf_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [tsgf_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic [tsgf_pkg::DATA_W-1:0]     s_tdata,
	input  logic                             s_tlast,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [tsgf_pkg::DATA_W-1:0]     m_tdata,
	output logic [tsgf_pkg::OUT_USER_W-1:0] m_tuser,
	output logic                             m_tlast,
	input  tsgf_pkg::cmd_t                   cmd,
	output tsgf_pkg::sts_t                   sts
);
	import tsgf_pkg::*;

	localparam int USED  = (COMPONENTS < NUM_VALUES) ? COMPONENTS : NUM_VALUES;
	localparam int BUD_W = $clog2(MAX_FILLS + 1);
	localparam logic [BUD_W-1:0] BUD_FULL = BUD_W'(MAX_FILLS);

	// configuration
	logic [TIME_W-1:0] res_q;
	logic [VAL_W-1:0]  fill_q;
	logic [TIME_W-1:0] minb_q;
	logic              min_en_q;
	logic [TIME_W-1:0] maxb_q;
	logic              max_en_q;

	// current request and series state
	logic [TIME_W-1:0] t_q;
	logic [VAL_W-1:0]  val_q [NUM_VALUES];
	logic              final_q;
	logic [TIME_W-1:0] prev_q;
	logic              have_prev_q;

	// fill stepping
	logic [TIME_W:0]   cand_q;
	logic [BUD_W-1:0]  budget_q;
	logic              dropped_q;

	// remainder unit
	logic [TIME_W-1:0] dvd_q;
	logic [TIME_W-1:0] rem_q;
	logic [CNT_W-1:0]  cnt_q;

	// output register
	logic              out_valid_q;
	logic [TIME_W-1:0] out_time_q;
	logic [VAL_W-1:0]  out_val_q [NUM_VALUES];
	logic              out_fill_q;
	logic              out_end_q;
	logic              out_drop_q;

	logic [TIME_W-1:0] in_time;
	logic              res_nz;
	logic [TIME_W:0]   res_x;
	logic [TIME_W:0]   rem_sh;
	logic [TIME_W:0]   rem_sub;
	logic [TIME_W-1:0] rem_nx;
	logic              pre_in;
	logic [TIME_W:0]   cand_nx;
	logic [TIME_W:0]   t_step;
	logic              trail_in;
	logic [BUD_W-1:0]  budget_dec;
	logic              next_in;
	logic              emit;
	logic [TIME_W-1:0] o_time;
	logic [VAL_W-1:0]  o_val [NUM_VALUES];
	logic              o_fill;
	logic              o_end;
	logic              o_drop;

	assign in_time = s_tdata[TIME_W-1:0];
	assign res_nz  = res_q != '0;
	assign res_x   = {1'b0, res_q};

	// restoring remainder step
	assign rem_sh  = {rem_q, dvd_q[TIME_W-1]};
	assign rem_sub = rem_sh - res_x;
	assign rem_nx  = (rem_sh >= res_x) ? rem_sub[TIME_W-1:0] : rem_sh[TIME_W-1:0];

	assign pre_in     = cand_q < {1'b0, t_q};
	assign cand_nx    = cand_q + res_x;
	assign t_step     = {1'b0, t_q} + res_x;
	assign trail_in   = final_q && res_nz && max_en_q && (t_step <= {1'b0, maxb_q});
	assign budget_dec = budget_q - BUD_W'(1);
	assign next_in    = cand_nx <= {1'b0, maxb_q};

	assign sts.out_free  = !out_valid_q || m_tready;
	assign sts.go_gap    = res_nz && have_prev_q && (in_time > prev_q);
	assign sts.go_lead   = res_nz && !have_prev_q && min_en_q && (minb_q < in_time);
	assign sts.div_done  = cnt_q == CNT_W'(DIV_STEPS);
	assign sts.pre_fill  = pre_in && (budget_q != '0);
	assign sts.trail_go  = trail_in && (budget_q != '0);
	assign sts.post_last = !(next_in && (budget_dec != '0));

	assign emit = cmd.pre_step || cmd.samp_step || cmd.post_step;

	always_comb begin
		o_time = cand_q[TIME_W-1:0];
		o_fill = 1'b1;
		o_end  = 1'b0;
		o_drop = 1'b0;
		if (cmd.samp_step) begin
			o_time = t_q;
			o_fill = 1'b0;
			o_end  = !sts.trail_go;
			o_drop = !sts.trail_go && (dropped_q || (trail_in && (budget_q == '0)));
		end else if (cmd.post_step) begin
			o_end  = sts.post_last;
			o_drop = sts.post_last && (dropped_q || (next_in && (budget_dec == '0)));
		end
	end

	// components beyond the configured count read as zero
	always_comb begin
		for (int j = 0; j < NUM_VALUES; j++) begin
			if (j < USED) begin
				o_val[j] = cmd.samp_step ? val_q[j] : fill_q;
			end else begin
				o_val[j] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q    <= TIME_W'(1);
			fill_q   <= '0;
			minb_q   <= '0;
			min_en_q <= 1'b0;
			maxb_q   <= '0;
			max_en_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_RESOLUTION: res_q    <= cfg_wdata[TIME_W-1:0];
				REG_FILL_VALUE: fill_q   <= cfg_wdata[VAL_W-1:0];
				REG_MIN_BOUND:  minb_q   <= cfg_wdata[TIME_W-1:0];
				REG_MIN_ENABLE: min_en_q <= cfg_wdata[0];
				REG_MAX_BOUND:  maxb_q   <= cfg_wdata[TIME_W-1:0];
				REG_MAX_ENABLE: max_en_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
			budget_q    <= '0;
			dropped_q   <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				budget_q  <= BUD_FULL;
				dropped_q <= 1'b0;
				cnt_q     <= '0;
			end
			if (cmd.div_step) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.pre_step || cmd.post_step) begin
				budget_q <= budget_dec;
			end
			if (cmd.pre_end) begin
				dropped_q <= dropped_q || pre_in;
			end
			if (cmd.samp_step) begin
				have_prev_q <= !final_q;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			t_q     <= in_time;
			final_q <= s_tlast;
			for (int j = 0; j < NUM_VALUES; j++) begin
				val_q[j] <= s_tdata[TIME_W + j * VAL_W +: VAL_W];
			end
			cand_q <= {1'b0, prev_q} + res_x;
			dvd_q  <= in_time - minb_q;
			rem_q  <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= rem_nx;
			dvd_q <= {dvd_q[TIME_W-2:0], 1'b0};
		end
		// first leading fill sits at the bound plus the remainder
		if (cmd.lead_start) begin
			cand_q <= {1'b0, minb_q} + {1'b0, rem_q};
		end
		if (cmd.pre_step || cmd.post_step) begin
			cand_q <= cand_nx;
		end
		if (cmd.samp_step) begin
			prev_q <= t_q;
			cand_q <= t_step;
		end
		if (emit) begin
			out_time_q <= o_time;
			out_fill_q <= o_fill;
			out_end_q  <= o_end;
			out_drop_q <= o_drop;
			for (int j = 0; j < NUM_VALUES; j++) begin
				out_val_q[j] <= o_val[j];
			end
		end
	end

	assign m_tvalid                 = out_valid_q;
	assign m_tlast                  = out_end_q;
	assign m_tuser[USER_IS_FILL]    = out_fill_q;
	assign m_tuser[USER_DROPPED]    = out_drop_q;
	assign m_tdata[TIME_W-1:0]      = out_time_q;

	for (genvar g = 0; g < NUM_VALUES; g++) begin : g_out_val
		assign m_tdata[TIME_W + g * VAL_W +: VAL_W] = out_val_q[g];
	end

endmodule

FILE: rtl/time_series_gap_filler_unit.sv
// ----------------------------------------------------------------------------
// time_series_gap_filler_unit: time series gap filler
// passes time-stamped samples through and inserts fill samples in gaps and
// before or after a series up to configured bounds
// ----------------------------------------------------------------------------
//  channel  direction  signals                    content
//  cfg      in         cfg_we cfg_addr cfg_wdata  register writes, no read-back
//  s_axis   in         tvalid tready tdata tlast  samples, tlast = final sample
//  m_axis   out        tvalid tready tdata tuser  samples and fills, tlast = run end
//
//  a sample is accepted, then its result is emitted; each fill adds one more result
//  a time beyond the previous sample adds a step that closes the gap, fills or not
//  a series start past an enabled lower bound adds the remainder division and a step that places the first leading fill
//  a low m_axis_tready holds the output register and stalls the sequencer
//  reset clears the series state and loads the register defaults at once
// ----------------------------------------------------------------------------
module time_series_gap_filler_unit #(
	parameter int COMPONENTS = tsgf_pkg::DEF_COMPONENTS,
	parameter int MAX_FILLS  = tsgf_pkg::DEF_MAX_FILLS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tsgf_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [tsgf_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// sample_time, value_a, value_b, value_c, value_d
	input  logic [tsgf_pkg::DATA_W-1:0]     s_axis_tdata,
	input  logic                             s_axis_tlast,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// out_time, out_a, out_b, out_c, out_d
	output logic [tsgf_pkg::DATA_W-1:0]     m_axis_tdata,
	// is_fill, fills_dropped
	output logic [tsgf_pkg::OUT_USER_W-1:0] m_axis_tuser,
	output logic                             m_axis_tlast
);
	import tsgf_pkg::*;

	cmd_t cmd;
	sts_t sts;

	tsgf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.cmd     (cmd),
		.sts     (sts)
	);

	tsgf_dp #(
		.COMPONENTS (COMPONENTS),
		.MAX_FILLS  (MAX_FILLS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_axis_tdata),
		.s_tlast   (s_axis_tlast),
		.m_tvalid  (m_axis_tvalid),
		.m_tready  (m_axis_tready),
		.m_tdata   (m_axis_tdata),
		.m_tuser   (m_axis_tuser),
		.m_tlast   (m_axis_tlast),
		.cmd       (cmd),
		.sts       (sts)
	);

`ifndef SYNTHESIS
	// dropped fills are only reported on the last result of a run
	a_drop_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[USER_DROPPED] |-> m_axis_tlast)
		else $error("fills_dropped set on a result that is not a run end");

	// one request at a time
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request accepted while the previous one is in flight");

	// the output register is never overwritten while it still holds a result
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pre_step || cmd.samp_step || cmd.post_step |-> sts.out_free)
		else $error("result written into an occupied output register");

	// trailing fills follow their sample before a new request is accepted
	a_post_after_samp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.samp_step && sts.trail_go |=> !s_axis_tready)
		else $error("trailing fills abandoned after the sample");
`endif

endmodule
